[hw/rtl/tlbpt_pkg.sv]
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared types and constants for the TLB / page map translator
// Sizes, payload structs and the control structs passed between units.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int unsigned TLB_ENTRIES = 16;
  localparam int unsigned FRAME_COUNT = 128;
  localparam int unsigned PAGE_COUNT  = 256;
  localparam int unsigned PAGE_SIZE   = 256;

  localparam int unsigned TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int unsigned PAGE_W    = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W   = $clog2(FRAME_COUNT);
  localparam int unsigned OFFS_W    = $clog2(PAGE_SIZE);
  localparam int unsigned USED_W    = $clog2(FRAME_COUNT + 1);

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;

  // Input beat
  typedef struct packed {
    logic [7:0] virtual_page;
    logic [7:0] page_offset;
  } xlate_req_t;

  // Output beat
  typedef struct packed {
    logic [14:0] physical_address;
    logic [6:0]  frame_number;
    logic        tlb_hit;
    logic        page_fault;
    logic        evicted_valid;
    logic [7:0]  evicted_page;
  } xlate_rsp_t;

  // TLB search result
  typedef struct packed {
    logic   hit;
    frame_t frame;
  } tlb_look_t;

  // TLB update: drop entries of an evicted page, then fill one slot
  typedef struct packed {
    logic   inval;
    page_t  inval_page;
    logic   insert;
    page_t  page;
    frame_t frame;
  } tlb_upd_t;

  // Page map read data
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } pmap_rd_t;

  // Page map update: clear the evicted page, set the new mapping
  typedef struct packed {
    logic   clr;
    page_t  clr_page;
    logic   set;
    page_t  page;
    frame_t frame;
  } pmap_upd_t;

  // Frame allocator offer for a fault
  typedef struct packed {
    logic   full;
    frame_t frame;
  } alloc_t;

endpackage

[hw/rtl/tlbpt_tlb.sv]
// ----------------------------------------------------------------------------
// tlbpt_tlb: fully associative TLB
// Register-based entries, parallel tag compare, round-robin fill.
// ----------------------------------------------------------------------------
module tlbpt_tlb (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbpt_pkg::page_t    look_page_i,
  output tlbpt_pkg::tlb_look_t look_o,
  input  tlbpt_pkg::tlb_upd_t upd_i
);

  logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_q, valid_d;
  tlbpt_pkg::page_t                  tag_q   [tlbpt_pkg::TLB_ENTRIES];
  tlbpt_pkg::frame_t                 frame_q [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::TLB_IDX_W-1:0]   slot_q, slot_d;

  // first matching entry wins (at most one matches in practice)
  always_comb begin
    look_o = '0;
    for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == look_page_i) begin
        look_o.hit   = 1'b1;
        look_o.frame = frame_q[i];
      end
    end
  end

  assign slot_d = (slot_q == tlbpt_pkg::TLB_IDX_W'(tlbpt_pkg::TLB_ENTRIES - 1))
                ? '0 : slot_q + 1'b1;

  always_comb begin
    valid_d = valid_q;
    if (upd_i.inval) begin
      for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
        if (tag_q[i] == upd_i.inval_page) valid_d[i] = 1'b0;
      end
    end
    // fill after the invalidate so a reused slot ends up valid
    if (upd_i.insert) valid_d[slot_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      slot_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (upd_i.insert) slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.insert) begin
      tag_q[slot_q]   <= upd_i.page;
      frame_q[slot_q] <= upd_i.frame;
    end
  end

endmodule

[hw/rtl/tlbpt_pmap.sv]
// ----------------------------------------------------------------------------
// tlbpt_pmap: page map
// Frame memory with synchronous read, valid bit per page in flops.
// ----------------------------------------------------------------------------
module tlbpt_pmap (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  tlbpt_pkg::page_t     rd_page_i,
  input  tlbpt_pkg::page_t     vld_page_i,
  output tlbpt_pkg::pmap_rd_t  rd_o,
  input  tlbpt_pkg::pmap_upd_t upd_i
);

  tlbpt_pkg::frame_t                mem [tlbpt_pkg::PAGE_COUNT];
  tlbpt_pkg::frame_t                rd_frame_q;
  logic [tlbpt_pkg::PAGE_COUNT-1:0] valid_q, valid_d;

  always_ff @(posedge clk_i) begin
    if (upd_i.set) mem[upd_i.page] <= upd_i.frame;
    if (rd_en_i)   rd_frame_q <= mem[rd_page_i];
  end

  // evicted page and faulting page always differ
  always_comb begin
    valid_d = valid_q;
    if (upd_i.clr) valid_d[upd_i.clr_page] = 1'b0;
    if (upd_i.set) valid_d[upd_i.page]     = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_o.valid = valid_q[vld_page_i];
  assign rd_o.frame = rd_frame_q;

endmodule

[hw/rtl/tlbpt_falloc.sv]
// ----------------------------------------------------------------------------
// tlbpt_falloc: frame allocator
// Hands out fresh frames, then FIFO reuse; owner memory names the victim.
// ----------------------------------------------------------------------------
module tlbpt_falloc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  output tlbpt_pkg::alloc_t   alloc_o,
  output tlbpt_pkg::page_t    owner_o,
  input  logic                commit_i,
  input  tlbpt_pkg::page_t    commit_page_i
);

  tlbpt_pkg::page_t                 owner_mem [tlbpt_pkg::FRAME_COUNT];
  tlbpt_pkg::page_t                 owner_q;
  tlbpt_pkg::frame_t                oldest_q, oldest_d;
  logic [tlbpt_pkg::USED_W-1:0]     used_q;

  assign alloc_o.full  = (used_q == tlbpt_pkg::USED_W'(tlbpt_pkg::FRAME_COUNT));
  assign alloc_o.frame = alloc_o.full ? oldest_q : used_q[tlbpt_pkg::FRAME_W-1:0];
  assign owner_o       = owner_q;

  assign oldest_d = (oldest_q == tlbpt_pkg::FRAME_W'(tlbpt_pkg::FRAME_COUNT - 1))
                  ? '0 : oldest_q + 1'b1;

  // owner of the FIFO head is fetched when the beat is taken
  always_ff @(posedge clk_i) begin
    if (commit_i) owner_mem[alloc_o.frame] <= commit_page_i;
    if (rd_en_i)  owner_q <= owner_mem[oldest_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      used_q   <= '0;
    end else if (commit_i) begin
      if (alloc_o.full) oldest_q <= oldest_d;
      else              used_q   <= used_q + 1'b1;
    end
  end

endmodule

[hw/rtl/tlb_page_table_translator.sv]
// ----------------------------------------------------------------------------
// tlb_page_table_translator: virtual to physical page translation
// TLB, page map and FIFO frame replacement behind valid/ready channels.
// ----------------------------------------------------------------------------
// Each request beat carries a virtual page and a byte offset and yields one
// response beat. S_IDLE takes the beat and issues synchronous reads of the
// page map memory and of the owner memory at the FIFO head. S_LOOK searches
// the TLB, picks the frame (TLB, page map or allocator on a fault), writes
// back page map, owner memory and TLB, and waits while the output register
// is full and not draining. No new beat is taken before S_LOOK ends. The
// response sits in an output register, so a new request is taken
// while the previous response still waits. Frames are handed out 0, 1, 2 ...
// until all are used, then reused oldest first; the page that loses its frame
// is reported and dropped from page map and TLB. No clearing pass after reset.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  tlbpt_pkg::xlate_req_t req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output tlbpt_pkg::xlate_rsp_t rsp_o
);

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_e;

  state_e                 state_q;
  tlbpt_pkg::xlate_req_t  req_q;
  tlbpt_pkg::xlate_rsp_t  rsp_q, rsp_d;
  logic                   rsp_valid_q;

  logic                   take;
  logic                   fire;
  tlbpt_pkg::page_t       page;
  tlbpt_pkg::tlb_look_t   tlb_look;
  tlbpt_pkg::tlb_upd_t    tlb_upd;
  tlbpt_pkg::pmap_rd_t    pmap_rd;
  tlbpt_pkg::pmap_upd_t   pmap_upd;
  tlbpt_pkg::alloc_t      alloc;
  tlbpt_pkg::page_t       owner;
  tlbpt_pkg::frame_t      frame;
  logic                   fault;
  logic                   evict;

  assign req_ready_o = (state_q == S_IDLE);
  assign take        = req_valid_i && req_ready_o;
  // finish only when the output register is free or draining
  assign fire        = (state_q == S_LOOK) && (!rsp_valid_q || rsp_ready_i);

  assign page  = req_q.virtual_page[tlbpt_pkg::PAGE_W-1:0];
  assign fault = !tlb_look.hit && !pmap_rd.valid;
  assign evict = fault && alloc.full;

  always_comb begin
    priority if (tlb_look.hit) frame = tlb_look.frame;
    else if (pmap_rd.valid)    frame = pmap_rd.frame;
    else                       frame = alloc.frame;
  end

  always_comb begin
    tlb_upd.inval      = fire && evict;
    tlb_upd.inval_page = owner;
    tlb_upd.insert     = fire && !tlb_look.hit;
    tlb_upd.page       = page;
    tlb_upd.frame      = frame;

    pmap_upd.clr       = fire && evict;
    pmap_upd.clr_page  = owner;
    pmap_upd.set       = fire && fault;
    pmap_upd.page      = page;
    pmap_upd.frame     = frame;
  end

  always_comb begin
    rsp_d.physical_address = 15'({frame, req_q.page_offset[tlbpt_pkg::OFFS_W-1:0]});
    rsp_d.frame_number     = 7'(frame);
    rsp_d.tlb_hit          = tlb_look.hit;
    rsp_d.page_fault       = fault;
    rsp_d.evicted_valid    = evict;
    rsp_d.evicted_page     = evict ? 8'(owner) : '0;
  end

  tlbpt_tlb u_tlb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .look_page_i (page),
    .look_o      (tlb_look),
    .upd_i       (tlb_upd)
  );

  tlbpt_pmap u_pmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (take),
    .rd_page_i  (req_i.virtual_page[tlbpt_pkg::PAGE_W-1:0]),
    .vld_page_i (page),
    .rd_o       (pmap_rd),
    .upd_i      (pmap_upd)
  );

  tlbpt_falloc u_falloc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (take),
    .alloc_o       (alloc),
    .owner_o       (owner),
    .commit_i      (fire && fault),
    .commit_page_i (page)
  );

  always_ff @(posedge clk_i) begin
    if (take) req_q <= req_i;
    if (fire) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (take) state_q <= S_LOOK;
        S_LOOK: if (fire) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (fire)             rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[hw/rtl/tlbpt_checker.sv]
// ----------------------------------------------------------------------------
// tlbpt_checker: port-level checks for the translator
// Response flag consistency, output hold and request spacing.
// ----------------------------------------------------------------------------
module tlbpt_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_o,
  input logic                  rsp_valid_o,
  input logic                  rsp_ready_i,
  input tlbpt_pkg::xlate_rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.tlb_hit && rsp_o.page_fault))
    else $error("TLB hit flagged as page fault");

  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.evicted_valid |-> rsp_o.page_fault)
    else $error("eviction without page fault");

  a_addr_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.physical_address[14:8] == rsp_o.frame_number)
    else $error("physical address does not match frame");

  a_req_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken on back-to-back cycles");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

[test/tlb_page_table_translator_tb.sv]
// ----------------------------------------------------------------------------
// tlb_page_table_translator_tb: self-checking bench for the page translator
// Drives request beats with random gaps and response back-pressure, predicts
// every response from a behavioral model of TLB, page map and FIFO frame
// reuse, and compares each response beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_tb;
  import tlbpt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RECENT_DEPTH = 12;

  // Behavioral translator plus the queue of responses still owed by the DUT.
  class xlate_scoreboard;
    bit                 tlb_live[TLB_ENTRIES];
    bit [PAGE_W-1:0]    tlb_vpn[TLB_ENTRIES];
    bit [FRAME_W-1:0]   tlb_pfn[TLB_ENTRIES];
    int unsigned        tlb_fill_ptr;
    bit                 map_live[PAGE_COUNT];
    bit [FRAME_W-1:0]   map_pfn[PAGE_COUNT];
    bit [PAGE_W-1:0]    pfn_owner[FRAME_COUNT];
    int unsigned        reuse_head;
    int unsigned        pfns_issued;
    xlate_rsp_t         owed_q[$];
    int unsigned        errors;

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Translate one accepted request beat and queue the response it implies.
    function void note_request(xlate_req_t r);
      xlate_rsp_t       x;
      bit [PAGE_W-1:0]  vpn;
      bit [PAGE_W-1:0]  victim;
      bit [FRAME_W-1:0] pfn;
      int               slot;
      x = '0;
      vpn = r.virtual_page;
      pfn = '0;
      slot = -1;
      for (int i = 0; i < TLB_ENTRIES; i++)
        if (slot < 0 && tlb_live[i] && tlb_vpn[i] == vpn) slot = i;
      if (slot >= 0) begin
        pfn = tlb_pfn[slot];
        x.tlb_hit = 1'b1;
      end else begin
        if (map_live[vpn]) begin
          pfn = map_pfn[vpn];
        end else begin
          x.page_fault = 1'b1;
          if (pfns_issued < FRAME_COUNT) begin
            pfn = pfns_issued[FRAME_W-1:0];
            pfns_issued++;
          end else begin
            // all frames in use: take the oldest one back from its page
            pfn = reuse_head[FRAME_W-1:0];
            reuse_head = (reuse_head + 1) % FRAME_COUNT;
            victim = pfn_owner[pfn];
            x.evicted_valid = 1'b1;
            x.evicted_page = victim;
            map_live[victim] = 1'b0;
            for (int i = 0; i < TLB_ENTRIES; i++)
              if (tlb_vpn[i] == victim) tlb_live[i] = 1'b0;
          end
          map_live[vpn] = 1'b1;
          map_pfn[vpn] = pfn;
          pfn_owner[pfn] = vpn;
        end
        tlb_live[tlb_fill_ptr] = 1'b1;
        tlb_vpn[tlb_fill_ptr] = vpn;
        tlb_pfn[tlb_fill_ptr] = pfn;
        tlb_fill_ptr = (tlb_fill_ptr + 1) % TLB_ENTRIES;
      end
      x.frame_number = pfn;
      x.physical_address = {pfn, r.page_offset};
      owed_q.push_back(x);
    endfunction

    function void check_response(xlate_rsp_t got);
      xlate_rsp_t want;
      if (owed_q.size() == 0) begin
        $error("response beat with nothing outstanding: %p", got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.physical_address !== want.physical_address) begin
        $error("physical_address: expected %0h, got %0h",
               want.physical_address, got.physical_address);
        errors++;
      end
      if (got.frame_number !== want.frame_number) begin
        $error("frame_number: expected %0d, got %0d", want.frame_number, got.frame_number);
        errors++;
      end
      if (got.tlb_hit !== want.tlb_hit) begin
        $error("tlb_hit: expected %0b, got %0b", want.tlb_hit, got.tlb_hit);
        errors++;
      end
      if (got.page_fault !== want.page_fault) begin
        $error("page_fault: expected %0b, got %0b", want.page_fault, got.page_fault);
        errors++;
      end
      if (got.evicted_valid !== want.evicted_valid) begin
        $error("evicted_valid: expected %0b, got %0b", want.evicted_valid, got.evicted_valid);
        errors++;
      end
      if (got.evicted_page !== want.evicted_page) begin
        $error("evicted_page: expected %0h, got %0h", want.evicted_page, got.evicted_page);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  xlate_req_t  req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  xlate_rsp_t  rsp;

  xlate_scoreboard book;
  int unsigned     cycles = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  logic [7:0]      recent_q[$];
  logic [7:0]      hot_base;

  tlb_page_table_translator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Response side: check on handshake (pre-edge values), then roll ready.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid && rsp_ready) book.check_response(rsp);
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one request beat and hold it until accepted. Valid is only
  // dropped when a gap is actually taken, so back-to-back beats keep it high.
  task automatic send_request(input xlate_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk_i); while (!req_ready);
    book.note_request(r);
  endtask

  // Mix of recently used pages (TLB hits), a sliding working set (mostly
  // page map hits) and uniform pages, which keep faults and evictions coming.
  task automatic run_random(input int unsigned beats);
    xlate_req_t  r;
    int unsigned roll;
    hot_base = $urandom_range(255);
    for (int n = 0; n < beats; n++) begin
      roll = $urandom_range(99);
      if (roll < 30 && recent_q.size() > 0)
        r.virtual_page = recent_q[$urandom_range(recent_q.size() - 1)];
      else if (roll < 60)
        r.virtual_page = hot_base + 8'($urandom_range(47));
      else
        r.virtual_page = 8'($urandom_range(255));
      r.page_offset = 8'($urandom_range(255));
      send_request(r);
      recent_q.push_back(r.virtual_page);
      if (recent_q.size() > RECENT_DEPTH) void'(recent_q.pop_front());
      if ($urandom_range(99) < 2) hot_base = hot_base + 8'($urandom_range(31));
    end
  endtask

  initial begin
    xlate_req_t opening[$];
    book = new;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opener: field extremes, first faults, TLB hits, then enough
    // fresh pages to roll the TLB over so early pages hit in the page map.
    opening.push_back({8'h00, 8'h00});
    opening.push_back({8'h00, 8'hff});
    opening.push_back({8'hff, 8'hff});
    opening.push_back({8'hff, 8'h00});
    opening.push_back({8'h55, 8'haa});
    opening.push_back({8'haa, 8'h55});
    for (int i = 1; i <= 16; i++) opening.push_back({8'(i), 8'(i * 16)});
    opening.push_back({8'h00, 8'h80});
    opening.push_back({8'hff, 8'h01});

    send_idle_pct = 33;
    recv_idle_pct = 68;
    foreach (opening[i]) send_request(opening[i]);
    run_random(640);

    send_idle_pct = 68;
    recv_idle_pct = 33;
    run_random(630);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(630);
    req_valid <= 1'b0;

    while (book.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[tlb_page_table_translator.f]
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlbpt_tlb.sv
hw/rtl/tlbpt_pmap.sv
hw/rtl/tlbpt_falloc.sv
hw/rtl/tlb_page_table_translator.sv
hw/rtl/tlbpt_checker.sv
test/tlb_page_table_translator_tb.sv
